// ===== src/counted_key_hash_set_core_assert.svh =====
// Assertion macros shared by the counted key hash set RTL.
// No dependencies; included by modules that carry assertions.
`ifndef COUNTED_KEY_HASH_SET_CORE_ASSERT_SVH
`define COUNTED_KEY_HASH_SET_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CKHS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ckhs assertion failed");
`define CKHS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ckhs forbidden condition");
`else
`define CKHS_ASSERT(lbl, clk, rst, prop)
`define CKHS_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== src/ckhs_pkg.sv =====
// Package for the counted key hash set: sizes, codes and the job record.
// No dependencies.
`default_nettype none
package ckhs_pkg;
  localparam int MAX_BUCKETS = 4096;
  localparam int POOL_NODES  = 1024;
  localparam int KEY_BITS    = 48;
  localparam int MOD_W       = 13;
  localparam int CNT_W       = 31;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int NODE_W      = $clog2(POOL_NODES);
  localparam int LINK_W      = NODE_W + 1;
  localparam int STEP_W      = $clog2(KEY_BITS);

  localparam logic [LINK_W-1:0] NIL_NODE = LINK_W'(POOL_NODES);
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [MOD_W-1:0]  MOD_RESET = MOD_W'(31);
  localparam logic [MOD_W-1:0]  MOD_LIMIT = MOD_W'(MAX_BUCKETS);

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_BITS-1:0] key;
    logic [BKT_W-1:0]    bucket;
  } job_t;
endpackage
`default_nettype wire

// ===== src/ckhs_req_if.sv =====
// Request channel: mode and key with valid/ready.
// Depends on ckhs_pkg.
`default_nettype none
interface ckhs_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [ckhs_pkg::KEY_BITS-1:0] key;
  modport source (output valid, mode, key, input ready);
  modport sink (input valid, mode, key, output ready);
endinterface
`default_nettype wire

// ===== src/ckhs_rsp_if.sv =====
// Response channel: outcome, ref_count and pool_full with valid/ready.
// Depends on ckhs_pkg.
`default_nettype none
interface ckhs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       outcome;
  logic [ckhs_pkg::CNT_W-1:0] ref_count;
  logic                       pool_full;
  modport source (output valid, outcome, ref_count, pool_full, input ready);
  modport sink (input valid, outcome, ref_count, pool_full, output ready);
endinterface
`default_nettype wire

// ===== src/counted_key_hash_set_core.sv =====
// Counted key hash set: top level joining front, job queue and back.
// Depends on ckhs_pkg, ckhs_req_if, ckhs_rsp_if, ckhs_front, ckhs_queue, ckhs_back.
//
// Usage:
//  req channel: mode (0 count, 1 insert, 2 remove, 3 as count) and a 48-bit key.
//  rsp channel: one response per request, in order: outcome, ref_count, pool_full.
//  cfg_we/cfg_wdata write bucket_modulus (reset 31; 0 acts as 1, above 4096 as 4096);
//  write it only while no request is in flight.
// Operation:
//  The front works out the bucket as a bit-serial remainder over the 48 key
//  bits, then hands the job to a two-entry queue. The back reads the bucket head,
//  walks the chain (one node RAM read per cycle), then updates the count, the
//  links and the free list for insert or remove, and registers the response.
//  The front takes a new request once it has pushed the last job, so it can
//  work on it while the back is still busy with an earlier one.
// Reset:
//  rst is synchronous. Afterwards the back clears the 4096-entry bucket table,
//  one entry per cycle; requests queue in the front meanwhile.
// Stalls:
//  A held response stays in the output register; the front keeps accepting
//  until the queue fills.
`default_nettype none
module counted_key_hash_set_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [ckhs_pkg::MOD_W-1:0] cfg_wdata,
  ckhs_req_if.sink                        req,
  ckhs_rsp_if.source                      rsp
);
  logic           push;
  ckhs_pkg::job_t push_job;
  logic           not_full;
  logic           pop;
  ckhs_pkg::job_t pop_job;
  logic           not_empty;

  ckhs_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req),
    .push(push), .push_job(push_job), .not_full(not_full)
  );

  ckhs_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .not_full(not_full),
    .pop(pop), .pop_job(pop_job), .not_empty(not_empty)
  );

  ckhs_back u_back (
    .clk(clk), .rst(rst), .pop_job(pop_job), .not_empty(not_empty), .pop(pop),
    .rsp(rsp)
  );
endmodule
`default_nettype wire

// ===== src/ckhs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ckhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/ckhs_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on ckhs_pkg.
`default_nettype none
module ckhs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ckhs_pkg::job_t push_job,
  output logic               not_full,
  input  wire logic          pop,
  output ckhs_pkg::job_t     pop_job,
  output logic               not_empty
);
  ckhs_pkg::job_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_full  = (fill != 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'((push && not_full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// ===== src/ckhs_front.sv =====
// Front part: accepts requests, holds the modulus register, computes the bucket
// with a bit-serial restoring remainder. Depends on ckhs_pkg, ckhs_req_if.
`default_nettype none
module ckhs_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ckhs_pkg::MOD_W-1:0]    cfg_wdata,
  ckhs_req_if.sink                           req,
  output logic                               push,
  output ckhs_pkg::job_t                     push_job,
  input  wire logic                          not_full
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                          state;
  logic [ckhs_pkg::MOD_W-1:0]       bucket_modulus;
  logic [ckhs_pkg::MOD_W-1:0]       divisor;
  logic [ckhs_pkg::MOD_W-1:0]       rem;
  logic [ckhs_pkg::MOD_W-1:0]       rem_next;
  logic [ckhs_pkg::MOD_W:0]         trial;
  logic [ckhs_pkg::KEY_BITS-1:0]    shift;
  logic [ckhs_pkg::STEP_W-1:0]      step;
  logic [1:0]                       mode;
  logic [ckhs_pkg::KEY_BITS-1:0]    key;
  logic [ckhs_pkg::MOD_W-1:0]       eff_mod;

  always_comb begin
    if (bucket_modulus == '0) begin
      eff_mod = ckhs_pkg::MOD_W'(1);
    end else if (bucket_modulus > ckhs_pkg::MOD_LIMIT) begin
      eff_mod = ckhs_pkg::MOD_LIMIT;
    end else begin
      eff_mod = bucket_modulus;
    end
  end

  assign trial    = {rem, shift[ckhs_pkg::KEY_BITS-1]};
  assign rem_next = (trial >= {1'b0, divisor}) ?
                    ckhs_pkg::MOD_W'(trial - {1'b0, divisor}) : ckhs_pkg::MOD_W'(trial);

  assign req.ready       = (state == F_IDLE);
  assign push            = (state == F_PUSH);
  assign push_job.mode   = mode;
  assign push_job.key    = key;
  assign push_job.bucket = rem[ckhs_pkg::BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_modulus <= ckhs_pkg::MOD_RESET;
    end else if (cfg_we) begin
      bucket_modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (step == ckhs_pkg::STEP_W'(ckhs_pkg::KEY_BITS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (not_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req.valid) begin
      mode    <= req.mode;
      key     <= req.key;
      shift   <= req.key;
      divisor <= eff_mod;
      rem     <= '0;
      step    <= '0;
    end else if (state == F_DIV) begin
      rem   <= rem_next;
      shift <= {shift[ckhs_pkg::KEY_BITS-2:0], 1'b0};
      step  <= step + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== src/ckhs_back.sv =====
// Back part: clears the bucket table, walks chains, updates nodes and the free
// list, registers the response. Depends on ckhs_pkg, ckhs_ram, ckhs_rsp_if.
`default_nettype none
`include "counted_key_hash_set_core_assert.svh"
module ckhs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ckhs_pkg::job_t pop_job,
  input  wire logic           not_empty,
  output logic                pop,
  ckhs_rsp_if.source          rsp
);
  localparam int LW = ckhs_pkg::LINK_W;
  localparam int NW = ckhs_pkg::NODE_W;
  localparam int BW = ckhs_pkg::BKT_W;
  localparam int KW = ckhs_pkg::KEY_BITS;
  localparam int CW = ckhs_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_HEAD   = 9'b000000100,
    S_NODE   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_ALLOC  = 9'b000100000,
    S_LINKIN = 9'b001000000,
    S_FREE   = 9'b010000000,
    S_RESP   = 9'b100000000
  } bstate_t;

  bstate_t        state;
  logic [BW-1:0]  clr;
  ckhs_pkg::job_t job;
  logic [LW-1:0]  cur;
  logic [LW-1:0]  prev;
  logic [LW-1:0]  head;
  logic [LW-1:0]  nxt;
  logic           found;
  logic [NW-1:0]  node;
  logic [CW-1:0]  cnt;
  logic [LW-1:0]  free_head;
  logic [LW-1:0]  fresh;
  logic           res_outcome;
  logic [CW-1:0]  res_count;
  logic           res_full;
  logic           out_load;

  logic           bh_we;
  logic [BW-1:0]  bh_waddr;
  logic [LW-1:0]  bh_wdata;
  logic [LW-1:0]  bh_rdata;
  logic           key_we;
  logic           cnt_we;
  logic [NW-1:0]  cnt_waddr;
  logic [CW-1:0]  cnt_wdata;
  logic           link_we;
  logic [NW-1:0]  link_waddr;
  logic [LW-1:0]  link_wdata;
  logic [NW-1:0]  node_raddr;
  logic [KW-1:0]  key_rdata;
  logic [CW-1:0]  cnt_rdata;
  logic [LW-1:0]  link_rdata;
  logic [CW-1:0]  cnt_sat;

  assign pop      = (state == S_IDLE) && not_empty;
  assign out_load = (state == S_RESP) && (!rsp.valid || rsp.ready);
  assign cnt_sat  = (cnt == ckhs_pkg::COUNT_MAX) ? cnt : cnt + 1'b1;

  always_comb begin
    bh_we      = 1'b0;
    bh_waddr   = job.bucket;
    bh_wdata   = nxt;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = node;
    cnt_wdata  = CW'(1);
    link_we    = 1'b0;
    link_waddr = node;
    link_wdata = head;
    node_raddr = free_head[NW-1:0];
    unique case (state)
      S_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr;
        bh_wdata = ckhs_pkg::NIL_NODE;
      end
      S_HEAD: node_raddr = bh_rdata[NW-1:0];
      S_NODE: node_raddr = link_rdata[NW-1:0];
      S_DECIDE: begin
        if (job.mode == ckhs_pkg::MODE_INSERT && found) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_sat;
        end
        if (job.mode == ckhs_pkg::MODE_REMOVE && found) begin
          if (prev == ckhs_pkg::NIL_NODE) begin
            bh_we = 1'b1;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev[NW-1:0];
            link_wdata = nxt;
          end
        end
      end
      S_LINKIN: begin
        key_we   = 1'b1;
        cnt_we   = 1'b1;
        link_we  = 1'b1;
        bh_we    = 1'b1;
        bh_wdata = {1'b0, node};
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_wdata = free_head;
      end
      default: ;
    endcase
  end

  ckhs_ram #(.WIDTH(LW), .DEPTH(ckhs_pkg::MAX_BUCKETS)) u_bucket_head (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(pop_job.bucket), .rdata(bh_rdata)
  );
  ckhs_ram #(.WIDTH(KW), .DEPTH(ckhs_pkg::POOL_NODES)) u_node_key (
    .clk(clk), .we(key_we), .waddr(node), .wdata(job.key),
    .raddr(node_raddr), .rdata(key_rdata)
  );
  ckhs_ram #(.WIDTH(CW), .DEPTH(ckhs_pkg::POOL_NODES)) u_node_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(node_raddr), .rdata(cnt_rdata)
  );
  ckhs_ram #(.WIDTH(LW), .DEPTH(ckhs_pkg::POOL_NODES)) u_node_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_head <= ckhs_pkg::NIL_NODE;
      fresh     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(ckhs_pkg::MAX_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (not_empty) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= (bh_rdata == ckhs_pkg::NIL_NODE) ? S_DECIDE : S_NODE;
        end
        S_NODE: begin
          if (key_rdata == job.key || link_rdata == ckhs_pkg::NIL_NODE) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (job.mode == ckhs_pkg::MODE_INSERT && !found) begin
            if (free_head != ckhs_pkg::NIL_NODE) begin
              state <= S_ALLOC;
            end else if (fresh != ckhs_pkg::NIL_NODE) begin
              fresh <= fresh + 1'b1;
              state <= S_LINKIN;
            end else begin
              state <= S_RESP;
            end
          end else if (job.mode == ckhs_pkg::MODE_REMOVE && found) begin
            state <= S_FREE;
          end else begin
            state <= S_RESP;
          end
        end
        S_ALLOC: begin
          free_head <= link_rdata;
          state     <= S_LINKIN;
        end
        S_LINKIN: state <= S_RESP;
        S_FREE: begin
          free_head <= {1'b0, node};
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.outcome   <= res_outcome;
      rsp.ref_count <= res_count;
      rsp.pool_full <= res_full;
    end
    unique case (state)
      S_IDLE: begin
        job <= pop_job;
      end
      S_HEAD: begin
        head  <= bh_rdata;
        cur   <= bh_rdata;
        prev  <= ckhs_pkg::NIL_NODE;
        found <= 1'b0;
      end
      S_NODE: begin
        if (key_rdata == job.key) begin
          found <= 1'b1;
          node  <= cur[NW-1:0];
          cnt   <= cnt_rdata;
          nxt   <= link_rdata;
        end else begin
          prev <= cur;
          cur  <= link_rdata;
        end
      end
      S_DECIDE: begin
        res_outcome <= 1'b0;
        res_count   <= '0;
        res_full    <= 1'b0;
        if (job.mode == ckhs_pkg::MODE_INSERT) begin
          if (found) begin
            res_count <= cnt_sat;
          end else if (free_head != ckhs_pkg::NIL_NODE) begin
            node <= free_head[NW-1:0];
          end else if (fresh != ckhs_pkg::NIL_NODE) begin
            node <= fresh[NW-1:0];
          end else begin
            res_full <= 1'b1;
          end
        end else if (job.mode == ckhs_pkg::MODE_REMOVE) begin
          res_outcome <= found;
        end else if (found) begin
          res_count <= cnt;
        end
      end
      S_LINKIN: begin
        res_outcome <= 1'b1;
        res_count   <= CW'(1);
      end
      default: ;
    endcase
  end

  `CKHS_ASSERT(a_pop_idle, clk, rst, pop |-> (state == S_IDLE))
  `CKHS_ASSERT(a_walk_valid, clk, rst, (state == S_NODE) |-> (cur != ckhs_pkg::NIL_NODE))
  `CKHS_ASSERT(a_rsp_from_resp, clk, rst, $rose(rsp.valid) |-> $past(state == S_RESP))
  `CKHS_NEVER(a_fresh_bound, clk, rst, fresh > ckhs_pkg::NIL_NODE)
endmodule
`default_nettype wire
